// ===== src/mbpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpe_pkg
// Shared types and constants of the mask boundary pixel extractor.
// ----------------------------------------------------------------------------
package mbpe_pkg;

    localparam int CFG_W       = 11;  // width of a configuration register
    localparam int CFG_IDX_W   = 1;   // width of the register index
    localparam int COORD_W     = 10;  // width of a reported coordinate
    localparam int QUEUE_DEPTH = 4;   // items between front and back

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // per-item flags worked out by the front
    typedef struct packed {
        logic has_prev;   // a previous row exists, so a pixel gets decided
        logic cur;        // pixel below the one being decided (clear in drain)
        logic left_ok;    // decided pixel has a left neighbor in the frame
        logic right_ok;   // decided pixel has a right neighbor in the frame
        logic frame_end;  // last item of the drain row
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

// ===== src/mbpe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpe_front
// Holds frame geometry and raster counters; tags each item with its column,
// row and neighbor flags and hands it to the queue.
// ----------------------------------------------------------------------------
module mbpe_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int XW         = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mbpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbpe_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mask_bit,
    output logic                         o_q_valid,
    input  logic                         i_q_ready,
    output logic [XW-1:0]                o_x,
    output logic [mbpe_pkg::COORD_W-1:0] o_y,
    output mbpe_pkg::t_ctl               o_ctl
);
    import mbpe_pkg::*;

    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int DH    = (YW > CFG_W) ? YW : CFG_W;
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    logic [XW-1:0] r_wm1, n_wm1;   // frame width minus one
    logic [YW-1:0] r_h, n_h;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [DW-1:0] cfg_w_ext;
    logic [DH-1:0] cfg_h_ext;
    logic [XW-1:0] x;
    logic [YW-1:0] row_m1;
    logic          last, drain, accept;

    // clamp once at write time: zero means one, oversize saturates
    assign cfg_w_ext = DW'(i_cfg_data);
    assign cfg_h_ext = DH'(i_cfg_data);
    assign n_wm1 = (cfg_w_ext == '0) ? '0 :
                   (cfg_w_ext > DW'(MAX_WIDTH)) ? XW'(MAX_WIDTH - 1) :
                   XW'(cfg_w_ext - 1'b1);
    assign n_h   = (cfg_h_ext == '0) ? YW'(1) :
                   (cfg_h_ext > DH'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) :
                   YW'(cfg_h_ext);

    // a column past the end only follows a narrowing write
    assign x      = (r_col > r_wm1) ? r_wm1 : r_col;
    assign last   = (x == r_wm1);
    assign drain  = (r_row >= r_h);
    assign row_m1 = r_row - 1'b1;
    assign accept = i_in_valid && i_q_ready;

    assign o_in_ready         = i_q_ready;
    assign o_q_valid          = i_in_valid;
    assign o_x                = x;
    assign o_y                = COORD_W'(row_m1);
    assign o_ctl.has_prev     = (r_row != '0);
    assign o_ctl.cur          = !drain && i_mask_bit;
    assign o_ctl.left_ok      = (x != '0);
    assign o_ctl.right_ok     = !last;
    assign o_ctl.frame_end    = drain && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= XW'(RST_W - 1);
            r_h   <= YW'(RST_H);
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_wm1 <= n_wm1;
                    CFG_FRAME_HEIGHT: r_h   <= n_h;
                    default: ;
                endcase
            end
            if (accept) begin
                if (last) begin
                    r_col <= '0;
                    r_row <= (drain) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= x + 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/mbpe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpe_queue
// Small FIFO that decouples the front from the line store stage.
// ----------------------------------------------------------------------------
module mbpe_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != (PW + 1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/mbpe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpe_back
// Line store read, boundary decision, line store write and result register.
// The store is split into a previous-row bank and an older-row bank.
// ----------------------------------------------------------------------------
module mbpe_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int XW        = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  logic [XW-1:0]                i_x,
    input  logic [mbpe_pkg::COORD_W-1:0] i_y,
    input  mbpe_pkg::t_ctl               i_ctl,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mbpe_pkg::COORD_W-1:0] o_point_x,
    output logic [mbpe_pkg::COORD_W-1:0] o_point_y,
    output logic                         o_has_point,
    output logic                         o_frame_end
);
    import mbpe_pkg::*;

    logic r_mem_lo [MAX_WIDTH];   // previous row
    logic r_mem_hi [MAX_WIDTH];   // row before the previous one

    logic               r_s1_valid;
    logic [XW-1:0]      r_s1_x;
    logic [COORD_W-1:0] r_s1_y;
    t_ctl               r_s1_ctl;
    logic               r_rd_c0, r_rd_r0, r_rd_c1, r_rd_l1;
    logic               r_fwd_c, r_fwd_r, r_fwd_l, r_fwd_lo, r_fwd_hi;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic               r_out_pt, r_out_fe;

    logic [XW-1:0] addr_r, addr_l;
    logic          s1_fire, pop;
    logic          c0, up, left, right, center, point, wr_lo, wr_hi;

    assign addr_r  = i_x + 1'b1;
    assign addr_l  = i_x - 1'b1;
    assign s1_fire = r_s1_valid && (!r_out_valid || i_out_ready);
    assign pop     = i_q_valid && (!r_s1_valid || s1_fire);
    assign o_q_pop = pop;

    // the item leaving the stage writes in the same cycle a new one reads
    assign c0     = r_fwd_c ? r_fwd_lo : r_rd_c0;
    assign up     = r_fwd_c ? r_fwd_hi : r_rd_c1;
    assign right  = r_fwd_r ? r_fwd_lo : r_rd_r0;
    assign left   = r_fwd_l ? r_fwd_hi : r_rd_l1;
    assign center = r_s1_ctl.has_prev && c0;
    assign point  = center && !(up && r_s1_ctl.cur &&
                                r_s1_ctl.left_ok && left &&
                                r_s1_ctl.right_ok && right);
    assign wr_lo  = r_s1_ctl.cur;
    assign wr_hi  = center;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem_lo[r_s1_x] <= wr_lo;
            r_mem_hi[r_s1_x] <= wr_hi;
        end
        if (pop) begin
            r_rd_c0  <= r_mem_lo[i_x];
            r_rd_r0  <= r_mem_lo[addr_r];
            r_rd_c1  <= r_mem_hi[i_x];
            r_rd_l1  <= r_mem_hi[addr_l];
            r_fwd_c  <= s1_fire && (i_x == r_s1_x);
            r_fwd_r  <= s1_fire && (addr_r == r_s1_x);
            r_fwd_l  <= s1_fire && (addr_l == r_s1_x);
            r_fwd_lo <= wr_lo;
            r_fwd_hi <= wr_hi;
            r_s1_x   <= i_x;
            r_s1_y   <= i_y;
            r_s1_ctl <= i_ctl;
        end
        if (s1_fire) begin
            r_out_x  <= point ? COORD_W'(r_s1_x) : '0;
            r_out_y  <= point ? r_s1_y : '0;
            r_out_pt <= point;
            r_out_fe <= r_s1_ctl.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= point || r_s1_ctl.frame_end;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_has_point = r_out_pt;
    assign o_frame_end = r_out_fe;

endmodule

// ===== src/mask_boundary_pixel_extract_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_boundary_pixel_extract_core
// An accepted item passes the queue, the stage-1 registers and the result register.
// Throughput: one item per cycle (one line store write) unless i_out_ready stalls.
// Reset: counters and queue clear, frame size returns to 1024 x 1024
// (saturated to the parameters); the line store is not cleared, as the
// first row of each frame writes it before it is read.
// ----------------------------------------------------------------------------
module mask_boundary_pixel_extract_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbpe_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mask_bit,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mbpe_pkg::COORD_W-1:0]   o_point_x,
    output logic [mbpe_pkg::COORD_W-1:0]   o_point_y,
    output logic                           o_has_point,
    output logic                           o_frame_end
);
    import mbpe_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int DATA_W = XW + COORD_W + CTL_W;

    logic               f_valid, f_ready, q_valid, q_pop;
    logic [XW-1:0]      f_x, q_x;
    logic [COORD_W-1:0] f_y, q_y;
    t_ctl               f_ctl, q_ctl;
    logic [DATA_W-1:0]  q_din, q_dout;

    mbpe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XW         (XW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mask_bit  (i_mask_bit),
        .o_q_valid   (f_valid),
        .i_q_ready   (f_ready),
        .o_x         (f_x),
        .o_y         (f_y),
        .o_ctl       (f_ctl)
    );

    assign q_din = {f_ctl, f_y, f_x};

    mbpe_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_din),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_dout)
    );

    assign {q_ctl, q_y, q_x} = q_dout;

    mbpe_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .XW        (XW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_x         (q_x),
        .i_y         (q_y),
        .i_ctl       (q_ctl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_has_point (o_has_point),
        .o_frame_end (o_frame_end)
    );

endmodule
